/* sv/ndb_bandwidth_measure_assert.svh */
// Assertion macros for the N dB bandwidth measurement block.
// No dependencies; the including scope must provide clk and rst_n.
`ifndef NDB_BANDWIDTH_MEASURE_ASSERT_SVH
`define NDB_BANDWIDTH_MEASURE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define NDB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ndb_bw_pkg.sv */
// Shared types and constants for the N dB bandwidth measurement block.
// No dependencies; imported by every module of the block.
package ndb_bw_pkg;

    localparam int LEVEL_W    = 16;
    localparam int TARGET_W   = 18;
    localparam int KEY_W      = 19;
    localparam int START_W    = 40;
    localparam int STEP_W     = 32;
    localparam int DROP_W     = 15;
    localparam int BW_W       = 42;
    localparam int FREQ_W     = 43;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_START_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FREQ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_LEVEL = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    localparam logic [START_W-1:0] START_FREQ_RST = 40'd0;
    localparam logic [STEP_W-1:0]  STEP_FREQ_RST  = 32'd1;
    localparam logic [DROP_W-1:0]  DROP_LEVEL_RST = 15'd300;

    // Control from the sequencer to the shared search unit.
    typedef struct packed {
        logic sample_valid;
        logic first;
        logic dist_mode;
    } srch_ctrl_t;

endpackage

/* sv/ndb_bw_search.sv */
// Shared compare unit: tracks the best sample of a scan, either the highest
// level or the level closest to the target. Depends on ndb_bw_pkg.
module ndb_bw_search import ndb_bw_pkg::*; #(
    parameter int AW = 10
) (
    input  logic                       clk,
    input  srch_ctrl_t                 ctrl,
    input  logic [AW-1:0]              sample_idx,
    input  logic signed [LEVEL_W-1:0]  level,
    input  logic signed [TARGET_W-1:0] target,
    output logic [AW-1:0]              best_idx,
    output logic signed [LEVEL_W-1:0]  best_level
);

    logic signed [KEY_W-1:0] best_key_reg;
    logic [AW-1:0]           best_idx_reg;

    logic signed [KEY_W-1:0] level_x;
    logic signed [KEY_W-1:0] target_x;
    logic signed [KEY_W-1:0] diff;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] cmp_a;
    logic signed [KEY_W-1:0] cmp_b;
    logic                    better;

    always_comb
    begin
        level_x  = KEY_W'(level);
        target_x = KEY_W'(target);
        diff     = level_x - target_x;
        key      = ctrl.dist_mode ? ((diff < 0) ? -diff : diff) : level_x;
        // One comparator: a strictly higher level, or a strictly smaller distance.
        cmp_a    = ctrl.dist_mode ? best_key_reg : key;
        cmp_b    = ctrl.dist_mode ? key : best_key_reg;
        better   = ctrl.first || (cmp_a > cmp_b);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sample_valid && better)
        begin
            best_key_reg <= key;
            best_idx_reg <= sample_idx;
        end
    end

    assign best_idx   = best_idx_reg;
    assign best_level = best_key_reg[LEVEL_W-1:0];

endmodule

/* sv/ndb_bandwidth_measure.sv */
// Top level of the N dB bandwidth measurement block: trace store, sequencer,
// shared multiplier and result register. Depends on ndb_bw_pkg, ndb_bw_search.
//
//   channel   direction  handshake              contents
//   -------   ---------  ---------------------  -----------------------------------------
//   input     in         in_valid / in_ready    level_sample, last_point
//   result    out        out_valid / out_ready  bandwidth_hz, left/right_freq_hz, status
//   config    in         cfg_write              cfg_index, cfg_data
//
// Each input word is taken while the block is idle and, while the store has room, written
// to the single-port trace store. The word flagged last_point closes the trace; the block
// then stops taking words while three scans read the store back one entry a cycle (peak,
// left side, right side), then the two marker positions are multiplied and added.
// The peak scan reads n - 1 entries and the two side scans about n - 1 between them,
// so the time a trace takes after its last word is bound by the single read port of
// the store; a trace of fewer than two points skips the scans and goes to the result.
// The result sits in an output register, so loading of the next trace starts while
// it waits; only a finished result waits for that register to be freed.
// Reset puts the control state in idle and the configuration registers at their defaults; the store
// itself is not cleared, as only entries written during the current trace are ever read.
module ndb_bandwidth_measure import ndb_bw_pkg::*; #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [LEVEL_W-1:0]      level_sample,
    input  logic                           last_point,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [BW_W-1:0]                bandwidth_hz,
    output logic [FREQ_W-1:0]              left_freq_hz,
    output logic [FREQ_W-1:0]              right_freq_hz,
    output logic [STATUS_W-1:0]            status,
    input  logic                           cfg_write,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = STEP_W + AW;
    localparam int SW = (PW > FREQ_W) ? PW : FREQ_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
    localparam logic [CW-1:0] MIN_CNT = CW'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEAK,
        ST_LEFT,
        ST_RIGHT,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN
    } state_t;

    // Trace store
    logic signed [LEVEL_W-1:0] mem [MAX_POINTS];
    logic signed [LEVEL_W-1:0] rd_data_reg;

    // Configuration
    logic [START_W-1:0] start_freq_reg;
    logic [STEP_W-1:0]  step_freq_reg;
    logic [DROP_W-1:0]  drop_level_reg;

    // Sequencer
    state_t                     state_reg;
    logic                       start_reg;
    logic                       iss_reg;
    logic [AW-1:0]              addr_reg;
    logic [AW-1:0]              hi_reg;
    logic                       rd_vld_reg;
    logic                       rd_last_reg;
    logic [AW-1:0]              rd_idx_reg;
    logic                       first_reg;
    logic [CW-1:0]              count_reg;
    logic                       ovf_reg;
    logic [CW-1:0]              n_reg;
    logic                       short_reg;
    logic                       dropped_reg;
    logic [AW-1:0]              peak_idx_reg;
    logic signed [TARGET_W-1:0] target_reg;
    logic [AW-1:0]              left_idx_reg;
    logic [AW-1:0]              right_idx_reg;
    logic [PW-1:0]              prod_reg;
    logic [PW-1:0]              lprod_reg;

    // Result register
    logic                       out_valid_reg;
    logic [BW_W-1:0]            bw_reg;
    logic [FREQ_W-1:0]          left_freq_reg;
    logic [FREQ_W-1:0]          right_freq_reg;
    logic [STATUS_W-1:0]        status_reg;

    logic                       in_fire;
    logic                       out_free;
    logic                       scanning;
    logic                       mem_we;
    logic                       mem_re;
    logic [AW-1:0]              mem_addr;
    logic [CW-1:0]              count_new;
    logic [CW-1:0]              n_m2_full;
    logic [AW-1:0]              n_m2;
    logic                       scan_done;
    srch_ctrl_t                 srch_ctrl;
    logic [AW-1:0]              best_idx;
    logic signed [LEVEL_W-1:0]  best_level;
    logic signed [TARGET_W-1:0] target_calc;
    logic [AW-1:0]              right_lo;
    logic [AW-1:0]              mul_idx;
    logic [PW-1:0]              mul_out;
    logic [SW-1:0]              left_sum;
    logic [SW-1:0]              right_sum;
    logic [SW-1:0]              bw_diff;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign scanning  = (state_reg == ST_PEAK) || (state_reg == ST_LEFT)
                       || (state_reg == ST_RIGHT);

    // Words past the store's capacity are dropped and only flagged.
    assign mem_we    = in_fire && (count_reg < MAX_CNT);
    assign mem_re    = scanning && iss_reg;
    assign mem_addr  = (state_reg == ST_IDLE) ? count_reg[AW-1:0] : addr_reg;
    assign count_new = mem_we ? (count_reg + CW'(1)) : count_reg;

    // The peak scan stops at the second-to-last point, as does the right-side scan unless the peak sits there.
    assign n_m2_full = n_reg - MIN_CNT;
    assign n_m2      = n_m2_full[AW-1:0];
    assign scan_done = rd_vld_reg && rd_last_reg;

    assign srch_ctrl.sample_valid = rd_vld_reg && scanning;
    assign srch_ctrl.first        = first_reg;
    assign srch_ctrl.dist_mode    = (state_reg != ST_PEAK);

    ndb_bw_search #(
        .AW (AW)
    ) u_search (
        .clk        (clk),
        .ctrl       (srch_ctrl),
        .sample_idx (rd_idx_reg),
        .level      (rd_data_reg),
        .target     (target_reg),
        .best_idx   (best_idx),
        .best_level (best_level)
    );

    // Target level: peak minus the drop, never overflows eighteen bits.
    assign target_calc = TARGET_W'(best_level)
                         - $signed({{(TARGET_W - DROP_W){1'b0}}, drop_level_reg});
    assign right_lo    = peak_idx_reg + AW'(1);

    // One multiplier serves both marker positions in turn.
    assign mul_idx   = (state_reg == ST_MUL_L) ? left_idx_reg : right_idx_reg;
    assign mul_out   = PW'(step_freq_reg) * PW'(mul_idx);

    assign left_sum  = SW'(start_freq_reg) + SW'(lprod_reg);
    assign right_sum = SW'(start_freq_reg) + SW'(prod_reg);
    // The right marker always lies above the left one, so the bandwidth is the
    // difference of the two products, wrapped to the output width.
    assign bw_diff   = SW'(prod_reg) - SW'(lprod_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= level_sample;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_freq_reg <= START_FREQ_RST;
            step_freq_reg  <= STEP_FREQ_RST;
            drop_level_reg <= DROP_LEVEL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_FREQ: start_freq_reg <= cfg_data[START_W-1:0];
                REG_STEP_FREQ:  step_freq_reg  <= cfg_data[STEP_W-1:0];
                REG_DROP_LEVEL: drop_level_reg <= cfg_data[DROP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            iss_reg       <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            first_reg     <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            short_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_vld_reg  <= mem_re;
            rd_last_reg <= mem_re && (addr_reg == hi_reg);
            rd_idx_reg  <= addr_reg;
            if (srch_ctrl.sample_valid)
            begin
                first_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        count_reg <= count_new;
                        if (!mem_we)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_point)
                        begin
                            count_reg   <= '0;
                            ovf_reg     <= 1'b0;
                            n_reg       <= count_new;
                            dropped_reg <= ovf_reg || !mem_we;
                            if (count_new < MIN_CNT)
                            begin
                                short_reg <= 1'b1;
                                state_reg <= ST_FIN;
                            end
                            else
                            begin
                                short_reg <= 1'b0;
                                start_reg <= 1'b1;
                                state_reg <= ST_PEAK;
                            end
                        end
                    end
                end

                ST_PEAK, ST_LEFT, ST_RIGHT:
                begin
                    if (start_reg)
                    begin
                        // Set up the scan range; the side scans base it on the previous scan's result.
                        start_reg <= 1'b0;
                        iss_reg   <= 1'b1;
                        first_reg <= 1'b1;
                        if (state_reg == ST_PEAK)
                        begin
                            addr_reg <= '0;
                            hi_reg   <= n_m2;
                        end
                        else if (state_reg == ST_LEFT)
                        begin
                            // A peak at the first point leaves just that point.
                            peak_idx_reg <= best_idx;
                            target_reg   <= target_calc;
                            addr_reg     <= '0;
                            hi_reg       <= (best_idx == '0) ? '0 : (best_idx - AW'(1));
                        end
                        else
                        begin
                            // A peak at the second-to-last point leaves the last one.
                            left_idx_reg <= best_idx;
                            addr_reg     <= right_lo;
                            hi_reg       <= (peak_idx_reg == n_m2) ? right_lo : n_m2;
                        end
                    end
                    else if (iss_reg)
                    begin
                        addr_reg <= addr_reg + AW'(1);
                        if (addr_reg == hi_reg)
                        begin
                            iss_reg <= 1'b0;
                        end
                    end

                    if (scan_done)
                    begin
                        if (state_reg == ST_PEAK)
                        begin
                            start_reg <= 1'b1;
                            state_reg <= ST_LEFT;
                        end
                        else if (state_reg == ST_LEFT)
                        begin
                            start_reg <= 1'b1;
                            state_reg <= ST_RIGHT;
                        end
                        else
                        begin
                            state_reg <= ST_MUL_L;
                        end
                    end
                end

                ST_MUL_L:
                begin
                    prod_reg      <= mul_out;
                    right_idx_reg <= best_idx;
                    state_reg     <= ST_MUL_R;
                end

                ST_MUL_R:
                begin
                    lprod_reg <= prod_reg;
                    prod_reg  <= mul_out;
                    state_reg <= ST_FIN;
                end

                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (short_reg)
                        begin
                            bw_reg         <= '0;
                            left_freq_reg  <= '0;
                            right_freq_reg <= '0;
                            status_reg     <= STATUS_SHORT;
                        end
                        else
                        begin
                            bw_reg         <= bw_diff[BW_W-1:0];
                            left_freq_reg  <= left_sum[FREQ_W-1:0];
                            right_freq_reg <= right_sum[FREQ_W-1:0];
                            status_reg     <= dropped_reg ? STATUS_DROPPED : STATUS_OK;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign bandwidth_hz  = bw_reg;
    assign left_freq_hz  = left_freq_reg;
    assign right_freq_hz = right_freq_reg;
    assign status        = status_reg;

endmodule

/* sv/ndb_bw_checker.sv */
// Port-level checks for the N dB bandwidth measurement block, bound to the top.
// Depends on ndb_bw_pkg and ndb_bandwidth_measure_assert.svh.
`include "ndb_bandwidth_measure_assert.svh"

module ndb_bw_checker import ndb_bw_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                last_point,
    input logic                out_valid,
    input logic                out_ready,
    input logic [BW_W-1:0]     bandwidth_hz,
    input logic [FREQ_W-1:0]   left_freq_hz,
    input logic [FREQ_W-1:0]   right_freq_hz,
    input logic [STATUS_W-1:0] status
);

    // The closing word of a trace always ends input: the search, or the finish step of a short trace, takes no words.
    `NDB_ASSERT_NEXT(a_last_closes_input, in_valid && in_ready && last_point, !in_ready, "input open after the last word of a trace")

    // A trace too short to measure reports zero for every figure.
    `NDB_ASSERT_SAME(a_short_is_zero, out_valid && (status == STATUS_SHORT), (bandwidth_hz == '0) && (left_freq_hz == '0) && (right_freq_hz == '0), "short trace with non-zero figures")

    // The bandwidth equals the distance between the two marker frequencies.
    `NDB_ASSERT_SAME(a_bw_matches_markers, out_valid && (status != STATUS_SHORT), BW_W'(right_freq_hz - left_freq_hz) == bandwidth_hz, "bandwidth disagrees with marker frequencies")

    // A stalled result word holds its valid flag, bandwidth and status.
    `NDB_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(bandwidth_hz) && $stable(status), "stalled result word changed")

endmodule

bind ndb_bandwidth_measure ndb_bw_checker u_checker (.*);
